FILE: rtl/mmr_pkg.sv
// shared types and constants of the market maker requote block
`default_nettype none
package mmr_pkg;

  localparam int PRICE_W     = 32;
  localparam int ID_W        = 32;
  localparam int QTY_W       = 32;
  localparam int THR_W       = 25;
  localparam int FRAC_W      = 24;
  localparam int PROD_W      = THR_W + PRICE_W;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int QDATA_W     = (PRICE_W > ID_W) ? PRICE_W : ID_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 104;

  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_SIZE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PRICE = 8'd3;

  localparam logic [PRICE_W-1:0] RST_SPREAD      = 32'd5000;
  localparam logic [QTY_W-1:0]   RST_ORDER_SIZE  = 32'd10;
  localparam logic [THR_W-1:0]   RST_THRESHOLD   = 25'd33554;
  localparam logic [PRICE_W-1:0] RST_START_PRICE = 32'd1000000;

  typedef enum logic [1:0] {
    OP_TRADE = 2'd0,
    OP_BOOK  = 2'd1,
    OP_TICK  = 2'd2,
    OP_ACK   = 2'd3
  } op_t;

  typedef enum logic {
    ACT_CANCEL = 1'b0,
    ACT_SUBMIT = 1'b1
  } act_t;

  typedef enum logic {
    SIDE_BID = 1'b0,
    SIDE_ASK = 1'b1
  } side_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DECIDE,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    STEP_CXL_BID,
    STEP_CXL_ASK,
    STEP_SUB_BID,
    STEP_SUB_ASK
  } step_t;

  typedef struct packed {
    logic [PRICE_W-1:0] spread;
    logic [QTY_W-1:0]   order_size;
    logic [THR_W-1:0]   threshold;
    logic [PRICE_W-1:0] start_price;
  } cfg_t;

  typedef struct packed {
    logic               is_tick;
    logic               side;
    logic               accepted;
    logic [QDATA_W-1:0] data;
  } qent_t;

endpackage
`default_nettype wire

FILE: rtl/mmr_front.sv
// front end: market data state, mid price and classification into the queue
`default_nettype none
module mmr_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [mmr_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire  [1:0]                       in_tuser,
  input  wire  [mmr_pkg::PRICE_W-1:0]      start_price,
  input  wire                              q_full,
  output logic                             q_push,
  output mmr_pkg::qent_t                   q_ent
);
  import mmr_pkg::*;

  logic [PRICE_W-1:0] trade_price, book_bid, book_ask;
  logic [ID_W-1:0]    ack_order_id;
  logic               bid_present, ask_present, ack_side, ack_accepted;
  op_t                op;
  logic               accept;

  logic [PRICE_W-1:0] trade_last_r, bid_r, ask_r, mid;
  logic               trade_valid_r, bid_valid_r, ask_valid_r;

  assign op           = op_t'(in_tuser);
  assign trade_price  = in_tdata[31:0];
  assign bid_present  = in_tdata[32];
  assign book_bid     = in_tdata[64:33];
  assign ask_present  = in_tdata[65];
  assign book_ask     = in_tdata[97:66];
  assign ack_side     = in_tdata[98];
  assign ack_accepted = in_tdata[99];
  assign ack_order_id = in_tdata[131:100];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (bid_valid_r && ask_valid_r) begin
      mid = {1'b0, bid_r[PRICE_W-1:1]} + {1'b0, ask_r[PRICE_W-1:1]}
          + {{(PRICE_W-1){1'b0}}, bid_r[0] & ask_r[0]};
    end else if (trade_valid_r) begin
      mid = trade_last_r;
    end else begin
      mid = start_price;
    end
  end

  always_comb begin
    q_push         = accept && (op == OP_TICK || op == OP_ACK);
    q_ent.is_tick  = (op == OP_TICK);
    q_ent.side     = ack_side;
    q_ent.accepted = ack_accepted;
    q_ent.data     = (op == OP_TICK) ? mid : ack_order_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trade_valid_r <= 1'b0;
      bid_valid_r   <= 1'b0;
      ask_valid_r   <= 1'b0;
    end else if (accept) begin
      if (op == OP_TRADE) begin
        trade_valid_r <= 1'b1;
      end
      if (op == OP_BOOK) begin
        bid_valid_r <= bid_present;
        ask_valid_r <= ask_present;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_TRADE) begin
      trade_last_r <= trade_price;
    end
    if (accept && op == OP_BOOK) begin
      bid_r <= book_bid;
      ask_r <= book_ask;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mmr_queue.sv
// short fifo between front and back end
`default_nettype none
module mmr_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  mmr_pkg::qent_t  push_ent,
  output logic            full,
  input  wire             pop,
  output logic            valid,
  output mmr_pkg::qent_t  pop_ent
);
  import mmr_pkg::*;

  qent_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     cnt_r;

  assign full    = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_ent = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mmr_back.sv
// back end: live orders, requote decision and result sequencer
`default_nettype none
module mmr_back (
  input  wire                               clk,
  input  wire                               rst_n,
  input  mmr_pkg::cfg_t                     cfg,
  input  wire                               q_valid,
  input  mmr_pkg::qent_t                    q_ent,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [mmr_pkg::OUT_TDATA_W-1:0]   out_tdata,  // side, price, quantity, cancel_id
  output logic                              out_tuser,  // action
  output logic                              out_tlast
);
  import mmr_pkg::*;

  bk_state_t          state_r, state_nxt;
  step_t              step_r, step_nxt, step_first;

  logic [PRICE_W-1:0] quoted_r, mid_r, diff_r, diff_nxt;
  logic               has_quoted_r;
  logic [ID_W-1:0]    live_id_r [2];
  logic [1:0]         live_vld_r, cxl_r;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [PRICE_W-1:0] bid_px_r, ask_px_r, bid_px_nxt, ask_px_nxt;
  logic [PRICE_W-2:0] half;
  logic [PRICE_W:0]   ask_sum;
  logic               need, decide_go, out_load;

  act_t               res_act;
  side_t              res_side;
  logic [PRICE_W-1:0] res_price;
  logic [QTY_W-1:0]   res_qty;
  logic [ID_W-1:0]    res_id;
  logic               res_last;

  logic               out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic               out_act_r, out_last_r;

  // tick arithmetic
  assign diff_nxt = (q_ent.data > quoted_r) ? q_ent.data - quoted_r : quoted_r - q_ent.data;
  assign prod_nxt = {{PRICE_W{1'b0}}, cfg.threshold} * {{THR_W{1'b0}}, quoted_r};
  assign need     = !has_quoted_r
                 || ((quoted_r != '0) && ({1'b0, diff_r, {FRAC_W{1'b0}}} > prod_r));

  assign half       = cfg.spread[PRICE_W-1:1];
  assign bid_px_nxt = (mid_r >= {1'b0, half}) ? mid_r - {1'b0, half} : '0;
  assign ask_sum    = {1'b0, mid_r} + {2'b0, half};
  assign ask_px_nxt = ask_sum[PRICE_W] ? '1 : ask_sum[PRICE_W-1:0];

  assign step_first = live_vld_r[SIDE_BID] ? STEP_CXL_BID :
                      live_vld_r[SIDE_ASK] ? STEP_CXL_ASK : STEP_SUB_BID;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      step_r  <= STEP_SUB_BID;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    decide_go = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_ent.is_tick) begin
            state_nxt = BK_DECIDE;
          end
        end
      end
      BK_DECIDE: begin
        if (need) begin
          decide_go = 1'b1;
          state_nxt = BK_EMIT;
          step_nxt  = step_first;
        end else begin
          state_nxt = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (!out_vld_r || out_tready) begin
          out_load = 1'b1;
          unique case (step_r)
            STEP_CXL_BID: step_nxt = cxl_r[SIDE_ASK] ? STEP_CXL_ASK : STEP_SUB_BID;
            STEP_CXL_ASK: step_nxt = STEP_SUB_BID;
            STEP_SUB_BID: step_nxt = STEP_SUB_ASK;
            STEP_SUB_ASK: state_nxt = BK_IDLE;
            default:      state_nxt = BK_IDLE;
          endcase
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    res_act   = ACT_SUBMIT;
    res_side  = SIDE_BID;
    res_price = '0;
    res_qty   = cfg.order_size;
    res_id    = '0;
    res_last  = 1'b0;
    unique case (step_r)
      STEP_CXL_BID: begin
        res_act = ACT_CANCEL;
        res_qty = '0;
        res_id  = live_id_r[SIDE_BID];
      end
      STEP_CXL_ASK: begin
        res_act  = ACT_CANCEL;
        res_side = SIDE_ASK;
        res_qty  = '0;
        res_id   = live_id_r[SIDE_ASK];
      end
      STEP_SUB_BID: begin
        res_price = bid_px_r;
      end
      STEP_SUB_ASK: begin
        res_side  = SIDE_ASK;
        res_price = ask_px_r;
        res_last  = 1'b1;
      end
      default: res_act = ACT_SUBMIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_vld_r   <= '0;
      has_quoted_r <= 1'b0;
      quoted_r     <= '0;
    end else if (q_pop && !q_ent.is_tick) begin
      live_vld_r[q_ent.side] <= q_ent.accepted;
    end else if (decide_go) begin
      live_vld_r   <= '0;
      has_quoted_r <= 1'b1;
      quoted_r     <= mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_ent.is_tick && q_ent.accepted) begin
      live_id_r[q_ent.side] <= q_ent.data[ID_W-1:0];
    end
    if (q_pop && q_ent.is_tick) begin
      mid_r  <= q_ent.data[PRICE_W-1:0];
      diff_r <= diff_nxt;
      prod_r <= prod_nxt;
    end
    if (decide_go) begin
      cxl_r    <= live_vld_r;
      bid_px_r <= bid_px_nxt;
      ask_px_r <= ask_px_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {7'b0, res_id, res_qty, res_price, res_side};
      out_act_r  <= res_act;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/market_maker_requote.sv
// top level of the market maker requote block
//
// Trades and top-of-book updates are taken one per cycle while the queue has
// room, and update the market state at once. Ticks and order acknowledgments
// pass through a four-entry queue to the back end, which applies an
// acknowledgment on pop and handles a tick in steps (difference and threshold
// product, then the compare, then one step per emitted result, two to four of
// them). A requote burst stalls the input only when four ticks or
// acknowledgments stack up behind it. The configuration port is always ready;
// registers are to be written between bursts; the block does not enforce it.
`default_nettype none
module market_maker_requote (
  input  wire                               clk,
  input  wire                               rst_n,
  // trade_price, bid_present, book_bid, ask_present, book_ask,
  // ack_side, ack_accepted, ack_order_id
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [mmr_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire  [1:0]                        in_tuser,   // op
  // side, price, quantity, cancel_id
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [mmr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser,  // action
  output logic                              out_tlast,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [mmr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [mmr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mmr_pkg::*;

  cfg_t  cfg_r;
  logic  q_push, q_full, q_pop, q_valid;
  qent_t q_push_ent, q_pop_ent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spread      <= RST_SPREAD;
      cfg_r.order_size  <= RST_ORDER_SIZE;
      cfg_r.threshold   <= RST_THRESHOLD;
      cfg_r.start_price <= RST_START_PRICE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SPREAD:      cfg_r.spread      <= cfg_data[PRICE_W-1:0];
        CFG_ORDER_SIZE:  cfg_r.order_size  <= cfg_data[QTY_W-1:0];
        CFG_THRESHOLD:   cfg_r.threshold   <= cfg_data[THR_W-1:0];
        CFG_START_PRICE: cfg_r.start_price <= cfg_data[PRICE_W-1:0];
        default: ;
      endcase
    end
  end

  mmr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .start_price (cfg_r.start_price),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ent       (q_push_ent)
  );

  mmr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_ent  (q_pop_ent)
  );

  mmr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_ent      (q_pop_ent),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: rtl/mmr_checker.sv
// port-level checks of the market maker requote block and their bind
`default_nettype none
module mmr_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [mmr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input wire                               out_tuser,
  input wire                               out_tlast
);
  import mmr_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // burst ends on the ask submit
  a_last_ask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == ACT_SUBMIT && out_tdata[0] == SIDE_ASK)
    else $error("last marker not on ask submit");

  // cancels carry no price or quantity and never end a burst
  a_cancel_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ACT_CANCEL |-> out_tdata[64:1] == '0 && !out_tlast)
    else $error("cancel with price, quantity or last");

  // bid submit is never last and carries no cancel id
  a_bid_then_ask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == ACT_SUBMIT && out_tdata[0] == SIDE_BID
      |-> !out_tlast && out_tdata[96:65] == '0)
    else $error("bid submit malformed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind market_maker_requote mmr_checker u_mmr_checker (.*);
`default_nettype wire
